FILE: rtl/npcs_pkg.sv
// Shared types, codes and constants for the nearest palette color search core.
`default_nettype none

package npcs_pkg;

    localparam int DEFAULT_PALETTE_ENTRIES = 256;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    localparam int COLOR_W = 24;
    localparam int DIST_W  = 18;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } npcs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;
        logic query_start;
        logic rd_en;
        logic rd_last;
    } npcs_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_done;
    } npcs_status_t;

endpackage

`default_nettype wire

FILE: rtl/nearest_palette_color_search_core.sv
// Top level of the nearest palette color search core.
// Load word: result strobed on done in the cycle after acceptance; busy stays low.
// Query word: the time from acceptance to done is set by the scan that reads one palette
// RAM entry per cycle plus a two-stage square and compare pipeline.
// Reset (rst_n, asynchronous) returns the controller to idle; palette contents are kept
// undefined until loaded. The done strobe is shown for one cycle and cannot be stalled.
`default_nettype none

module nearest_palette_color_search_core import npcs_pkg::*; #(
    parameter int PALETTE_ENTRIES = DEFAULT_PALETTE_ENTRIES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              req_type,
    input  wire logic [7:0]        entry_index,
    input  wire logic [7:0]        entry_red,
    input  wire logic [7:0]        entry_green,
    input  wire logic [7:0]        entry_blue,
    input  wire logic [14:0]       query_color,
    output logic                   done,
    output logic      [31:0]       packed_color,
    output logic      [7:0]        nearest_index,
    output logic      [DIST_W-1:0] nearest_distance
);

    npcs_cmd_t                          cmd;
    npcs_status_t                       status;
    logic [$clog2(PALETTE_ENTRIES)-1:0] rd_addr;

    npcs_ctrl #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .busy     (busy),
        .done     (done)
    );

    npcs_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .rd_addr          (rd_addr),
        .entry_index      (entry_index),
        .entry_red        (entry_red),
        .entry_green      (entry_green),
        .entry_blue       (entry_blue),
        .query_color      (query_color),
        .status           (status),
        .packed_color     (packed_color),
        .nearest_index    (nearest_index),
        .nearest_distance (nearest_distance)
    );

    // A load word is answered in the very next cycle.
    a_load_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_LOAD) |=> done)
        else $error("load word not answered in the next cycle");

    // The end of a scan returns the controller to idle with the result strobed.
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        status.scan_done |=> (done && !busy))
        else $error("scan end did not produce a result");

    // Palette reads happen only while busy, and never alongside a load.
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (busy && !cmd.load_we))
        else $error("palette read outside a scan");

endmodule

`default_nettype wire

FILE: rtl/npcs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/npcs_ctrl.sv
// Controller state machine: accepts words, sequences the palette scan, raises done.
`default_nettype none

module npcs_ctrl import npcs_pkg::*; #(
    parameter int PALETTE_ENTRIES = DEFAULT_PALETTE_ENTRIES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic                               req_type,
    input  wire npcs_status_t                       status,
    output npcs_cmd_t                               cmd,
    output logic      [$clog2(PALETTE_ENTRIES)-1:0] rd_addr,
    output logic                                    busy,
    output logic                                    done
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    npcs_state_t      state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        cmd.query_start = 1'b1;
                        cnt_next        = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cmd.rd_last = 1'b1;
                    state_next  = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // The last entry still travels through the compare pipeline.
                if (status.scan_done)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = cnt_reg;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;

endmodule

`default_nettype wire

FILE: rtl/npcs_dp.sv
// Datapath: palette RAM, distance pipeline, running minimum and result registers.
`default_nettype none

module npcs_dp import npcs_pkg::*; #(
    parameter int PALETTE_ENTRIES = DEFAULT_PALETTE_ENTRIES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire npcs_cmd_t                          cmd,
    input  wire logic [$clog2(PALETTE_ENTRIES)-1:0] rd_addr,
    input  wire logic [7:0]                         entry_index,
    input  wire logic [7:0]                         entry_red,
    input  wire logic [7:0]                         entry_green,
    input  wire logic [7:0]                         entry_blue,
    input  wire logic [14:0]                        query_color,
    output npcs_status_t                            status,
    output logic      [31:0]                        packed_color,
    output logic      [7:0]                         nearest_index,
    output logic      [DIST_W-1:0]                  nearest_distance
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int EXT_W = ((IDX_W > 8) ? IDX_W : 8) + 1;

    // Load side.
    logic [EXT_W-1:0]   idx_ext;
    logic               in_range;
    logic               is_last;
    logic [COLOR_W-1:0] wr_rgb;
    logic [31:0]        load_packed;

    assign idx_ext  = EXT_W'(entry_index);
    assign in_range = idx_ext < EXT_W'(PALETTE_ENTRIES);
    assign is_last  = idx_ext == EXT_W'(PALETTE_ENTRIES - 1);
    assign wr_rgb   = {entry_blue, entry_green, entry_red};
    assign load_packed = {(is_last ? ALPHA_CLEAR : ALPHA_OPAQUE), wr_rgb};

    logic [COLOR_W-1:0] rdata;

    npcs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (cmd.load_we && in_range),
        .waddr (idx_ext[IDX_W-1:0]),
        .wdata (wr_rgb),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // Expanded query components: (v << 3) + 4.
    logic [7:0] qr_reg, qg_reg, qb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            qr_reg <= {query_color[4:0], 3'b100};
            qg_reg <= {query_color[9:5], 3'b100};
            qb_reg <= {query_color[14:10], 3'b100};
        end
    end

    // Stage 1 marks the cycle in which RAM read data is valid.
    logic             s1_v_reg, s1_last_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_v_reg, s2_last_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [15:0]      s2_sqr_reg, s2_sqg_reg, s2_sqb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.rd_en;
            s2_v_reg <= s1_v_reg;
        end
    end

    logic signed [8:0]  dr, dg, db;
    logic signed [17:0] pr, pg, pb;

    assign dr = $signed({1'b0, qr_reg}) - $signed({1'b0, rdata[7:0]});
    assign dg = $signed({1'b0, qg_reg}) - $signed({1'b0, rdata[15:8]});
    assign db = $signed({1'b0, qb_reg}) - $signed({1'b0, rdata[23:16]});
    assign pr = dr * dr;
    assign pg = dg * dg;
    assign pb = db * db;

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= rd_addr;
        s1_last_reg <= cmd.rd_last;
        s2_idx_reg  <= s1_idx_reg;
        s2_last_reg <= s1_last_reg;
        s2_sqr_reg  <= pr[15:0];
        s2_sqg_reg  <= pg[15:0];
        s2_sqb_reg  <= pb[15:0];
    end

    // Running minimum; entry zero always seeds it, so ties keep the lowest index.
    logic [DIST_W-1:0] sum;
    logic              take;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;

    assign sum  = DIST_W'(s2_sqr_reg) + DIST_W'(s2_sqg_reg) + DIST_W'(s2_sqb_reg);
    assign take = s2_v_reg && ((s2_idx_reg == '0) || (sum < best_dist_reg));

    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        if (take)
        begin
            best_dist_next = sum;
            best_idx_next  = s2_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
    end

    assign status.scan_done = s2_v_reg && s2_last_reg;

    // Result registers.
    logic [IDX_W+7:0]  best_idx_ext;
    logic [31:0]       packed_reg;
    logic [7:0]        nidx_reg;
    logic [DIST_W-1:0] ndist_reg;

    assign best_idx_ext = (IDX_W + 8)'(best_idx_next);

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            packed_reg <= load_packed;
            nidx_reg   <= '0;
            ndist_reg  <= '0;
        end
        else if (status.scan_done)
        begin
            packed_reg <= '0;
            nidx_reg   <= best_idx_ext[7:0];
            ndist_reg  <= best_dist_next;
        end
    end

    assign packed_color     = packed_reg;
    assign nearest_index    = nidx_reg;
    assign nearest_distance = ndist_reg;

endmodule

`default_nettype wire
